FILE: sv/fft_64_point_radix2_assert.svh
// Assertion macros shared by the FFT block.
`ifndef FFT_64_POINT_RADIX2_ASSERT_SVH
`define FFT_64_POINT_RADIX2_ASSERT_SVH
`ifndef SYNTH
// property holds at every edge out of reset
`define FFT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("fft assertion failed");
// antecedent implies consequent in the same cycle
`define FFT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fft assertion failed");
`else
`define FFT_ASSERT(lbl, prop)
`define FFT_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: sv/fft64_pkg.sv
// ----------------------------------------------------------------------------
// fft64_pkg
// Constants, types and helper functions of the 64-point radix-2 FFT.
// ----------------------------------------------------------------------------
package fft64_pkg;

   localparam int POINTS    = 64;
   localparam int ADDR_W    = 6;
   localparam int SAMPLE_W  = 16;
   localparam int TW_W      = 16;
   localparam int DATA_W    = 23;
   localparam int PROD_W    = DATA_W + TW_W;
   localparam int QUEUE_D   = 4;
   localparam int QPTR_W    = 2;

   typedef struct packed {
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       last;
   } q_entry_type;

   typedef struct packed {
      logic signed [TW_W-1:0] re;
      logic signed [TW_W-1:0] im;
   } tw_type;

   typedef enum logic [9:0] {
      ST_LOAD    = 10'b0000000001,
      ST_RD_K    = 10'b0000000010,
      ST_RD_C    = 10'b0000000100,
      ST_MUL     = 10'b0000001000,
      ST_SUM     = 10'b0000010000,
      ST_WR_K    = 10'b0000100000,
      ST_WR_C    = 10'b0001000000,
      ST_EM_RD   = 10'b0010000000,
      ST_EM_LD   = 10'b0100000000,
      ST_EM_WAIT = 10'b1000000000
   } state_type;

   // cos(2*pi*k/64), Q1.15, quarter wave
   function automatic logic signed [TW_W-1:0] qcos(input logic [4:0] k);
      logic signed [TW_W-1:0] v;
      case (k)
         5'd0:  v = 16'sd32767;
         5'd1:  v = 16'sd32610;
         5'd2:  v = 16'sd32138;
         5'd3:  v = 16'sd31357;
         5'd4:  v = 16'sd30274;
         5'd5:  v = 16'sd28899;
         5'd6:  v = 16'sd27246;
         5'd7:  v = 16'sd25330;
         5'd8:  v = 16'sd23170;
         5'd9:  v = 16'sd20788;
         5'd10: v = 16'sd18205;
         5'd11: v = 16'sd15447;
         5'd12: v = 16'sd12540;
         5'd13: v = 16'sd9512;
         5'd14: v = 16'sd6393;
         5'd15: v = 16'sd3212;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   function automatic tw_type twiddle(input logic [4:0] k);
      tw_type w;
      if (k <= 5'd16) begin
         w.re = qcos(k);
         w.im = -qcos(5'd16 - k);
      end else begin
         w.re = -qcos(5'd0 - k);   // 32 - k modulo 32
         w.im = -qcos(k - 5'd16);
      end
      return w;
   endfunction

   function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] i);
      logic [ADDR_W-1:0] r;
      for (int b = 0; b < ADDR_W; b++) r[b] = i[ADDR_W-1-b];
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat(input logic signed [DATA_W+2:0] v);
      logic signed [DATA_W+2:0] hi;
      logic signed [DATA_W+2:0] lo;
      hi = (DATA_W+3)'((1 << (DATA_W-1)) - 1);
      lo = -hi - (DATA_W+3)'(1);
      if (v > hi)      return DATA_W'(hi);
      else if (v < lo) return DATA_W'(lo);
      else             return DATA_W'(v);
   endfunction

endpackage

FILE: sv/fft64_ram.sv
// ----------------------------------------------------------------------------
// fft64_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fft64_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/fft64_front.sv
// ----------------------------------------------------------------------------
// fft64_front
// Accepts samples, tags each with its bit-reversed address and frame end,
// and queues them for the compute engine.
// ----------------------------------------------------------------------------
`include "fft_64_point_radix2_assert.svh"

module fft64_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fft64_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [fft64_pkg::SAMPLE_W-1:0] req_sample_im,
   output logic                                 q_valid,
   output fft64_pkg::q_entry_type               q_entry,
   input  logic                                 q_pop
);

   fft64_pkg::q_entry_type          slot_ff [fft64_pkg::QUEUE_D];
   logic [fft64_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [fft64_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [fft64_pkg::QPTR_W:0]      count_ff, count_in;
   logic [fft64_pkg::ADDR_W-1:0]    load_count_ff, load_count_in;
   logic                            push;
   logic                            pop;
   fft64_pkg::q_entry_type          new_entry;

   assign req_stall = (count_ff == (fft64_pkg::QPTR_W+1)'(fft64_pkg::QUEUE_D));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      new_entry.addr = fft64_pkg::bit_rev(load_count_ff);
      new_entry.re   = req_sample_re;
      new_entry.im   = req_sample_im;
      new_entry.last = (load_count_ff == '1);
      wr_ptr_in      = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in      = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      load_count_in  = push ? load_count_ff + 1'b1 : load_count_ff;
      count_in       = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= new_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         load_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         load_count_ff <= load_count_in;
      end
   end

   `FFT_ASSERT(a_count_bound, count_ff <= (fft64_pkg::QPTR_W+1)'(fft64_pkg::QUEUE_D))
   `FFT_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == count_ff[fft64_pkg::QPTR_W-1:0])

endmodule

FILE: sv/fft64_back.sv
// ----------------------------------------------------------------------------
// fft64_back
// Loads queued samples into the work RAM, runs the six butterfly stages in
// place and streams the bins out in natural order.
// ----------------------------------------------------------------------------
`include "fft_64_point_radix2_assert.svh"

module fft64_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  fft64_pkg::q_entry_type             q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fft64_pkg::DATA_W-1:0] rsp_bin_re,
   output logic signed [fft64_pkg::DATA_W-1:0] rsp_bin_im,
   output logic                               rsp_bin_last
);

   localparam int DW = fft64_pkg::DATA_W;
   localparam int AW = fft64_pkg::ADDR_W;
   localparam int PW = fft64_pkg::PROD_W;
   localparam int SW = fft64_pkg::SAMPLE_W;

   fft64_pkg::state_type state_ff, state_in;
   logic [2:0]           stage_ff, stage_in;
   logic [AW-2:0]        bfly_ff, bfly_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [DW-1:0] xk_re_ff, xk_im_ff, xc_re_ff, xc_im_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [DW+1:0] t_re_ff, t_im_ff;
   logic signed [DW-1:0] bin_re_ff, bin_im_ff;
   logic                 bin_last_ff;

   logic                 we;
   logic [AW-1:0]        waddr, raddr;
   logic [2*DW-1:0]      wdata, rdata;
   logic signed [DW-1:0] rd_re, rd_im;

   logic [AW-2:0]        mask, jj;
   logic [AW-1:0]        addr_c, addr_k;
   fft64_pkg::tw_type    w;
   logic signed [PW:0]   q_re, q_im;
   logic                 last_bfly;

   assign rd_re = rdata[2*DW-1:DW];
   assign rd_im = rdata[DW-1:0];

   // butterfly addresses: insert a zero at bit 'stage' of the butterfly index
   always_comb begin
      mask      = ((AW-1)'(1) << stage_ff) - (AW-1)'(1);
      jj        = bfly_ff & mask;
      addr_c    = {bfly_ff & ~mask, 1'b0} | {1'b0, jj};
      addr_k    = addr_c | (AW'(1) << stage_ff);
      w         = fft64_pkg::twiddle((AW-1)'(jj << (3'd5 - stage_ff)));
      last_bfly = (stage_ff == 3'd5) && (bfly_ff == '1);
      q_re = (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff) + (PW+1)'(1 << (fft64_pkg::TW_W-2));
      q_im = (PW+1)'(p_ri_ff) + (PW+1)'(p_ir_ff) + (PW+1)'(1 << (fft64_pkg::TW_W-2));
   end

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      bfly_in      = bfly_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = addr_c;
      wdata        = '0;
      raddr        = addr_k;
      case (state_ff)
         fft64_pkg::ST_LOAD: begin
            q_pop = q_valid;
            we    = q_valid;
            waddr = q_entry.addr;
            wdata = {{(DW-SW){q_entry.re[SW-1]}}, q_entry.re,
                     {(DW-SW){q_entry.im[SW-1]}}, q_entry.im};
            if (q_valid && q_entry.last) begin
               state_in = fft64_pkg::ST_RD_K;
               stage_in = '0;
               bfly_in  = '0;
            end
         end
         fft64_pkg::ST_RD_K: begin
            raddr    = addr_k;
            state_in = fft64_pkg::ST_RD_C;
         end
         fft64_pkg::ST_RD_C: begin
            raddr    = addr_c;
            state_in = fft64_pkg::ST_MUL;
         end
         fft64_pkg::ST_MUL: state_in = fft64_pkg::ST_SUM;
         fft64_pkg::ST_SUM: state_in = fft64_pkg::ST_WR_K;
         fft64_pkg::ST_WR_K: begin
            we       = 1'b1;
            waddr    = addr_k;
            wdata    = {fft64_pkg::sat((DW+3)'(xc_re_ff) - (DW+3)'(t_re_ff)),
                        fft64_pkg::sat((DW+3)'(xc_im_ff) - (DW+3)'(t_im_ff))};
            state_in = fft64_pkg::ST_WR_C;
         end
         fft64_pkg::ST_WR_C: begin
            we    = 1'b1;
            waddr = addr_c;
            wdata = {fft64_pkg::sat((DW+3)'(xc_re_ff) + (DW+3)'(t_re_ff)),
                     fft64_pkg::sat((DW+3)'(xc_im_ff) + (DW+3)'(t_im_ff))};
            if (last_bfly) begin
               state_in = fft64_pkg::ST_EM_RD;
               idx_in   = '0;
            end else begin
               state_in = fft64_pkg::ST_RD_K;
               bfly_in  = bfly_ff + 1'b1;
               if (bfly_ff == '1) stage_in = stage_ff + 1'b1;
            end
         end
         fft64_pkg::ST_EM_RD: begin
            raddr    = idx_ff;
            state_in = fft64_pkg::ST_EM_LD;
         end
         fft64_pkg::ST_EM_LD: begin
            rsp_valid_in = 1'b1;
            state_in     = fft64_pkg::ST_EM_WAIT;
         end
         fft64_pkg::ST_EM_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + 1'b1;
               state_in     = (idx_ff == '1) ? fft64_pkg::ST_LOAD : fft64_pkg::ST_EM_RD;
            end
         end
         default: state_in = fft64_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == fft64_pkg::ST_RD_C) begin
         xk_re_ff <= rd_re;
         xk_im_ff <= rd_im;
      end
      if (state_ff == fft64_pkg::ST_MUL) begin
         xc_re_ff <= rd_re;
         xc_im_ff <= rd_im;
         p_rr_ff  <= xk_re_ff * w.re;
         p_ii_ff  <= xk_im_ff * w.im;
         p_ri_ff  <= xk_re_ff * w.im;
         p_ir_ff  <= xk_im_ff * w.re;
      end
      if (state_ff == fft64_pkg::ST_SUM) begin
         t_re_ff <= (DW+2)'(q_re >>> (fft64_pkg::TW_W-1));
         t_im_ff <= (DW+2)'(q_im >>> (fft64_pkg::TW_W-1));
      end
      if (state_ff == fft64_pkg::ST_EM_LD) begin
         bin_re_ff   <= rd_re;
         bin_im_ff   <= rd_im;
         bin_last_ff <= (idx_ff == '1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fft64_pkg::ST_LOAD;
         stage_ff     <= '0;
         bfly_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         bfly_ff      <= bfly_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   fft64_ram #(
      .WIDTH (2*DW),
      .DEPTH (fft64_pkg::POINTS)
   ) u_work (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_bin_re   = bin_re_ff;
   assign rsp_bin_im   = bin_im_ff;
   assign rsp_bin_last = bin_last_ff;

   `FFT_ASSERT_IMP(a_valid_state, rsp_valid_ff, state_ff == fft64_pkg::ST_EM_WAIT)
   `FFT_ASSERT_IMP(a_pop_state, q_pop, state_ff == fft64_pkg::ST_LOAD)
   `FFT_ASSERT_IMP(a_no_write_emit, we, !rsp_valid_ff)
   `FFT_ASSERT_IMP(a_stage_range, state_ff != fft64_pkg::ST_LOAD, stage_ff <= 3'd5)

endmodule

FILE: sv/fft_64_point_radix2.sv
// ----------------------------------------------------------------------------
// fft_64_point_radix2
// 64-point radix-2 DIT FFT, Q1.15 complex input, 23-bit unscaled bins.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one complex time sample per item; 64 items make a frame.
//   rsp_* carries the 64 bins of a frame in natural order, rsp_bin_last on
//   bin 63. An item moves when valid is high and stall is low.
//   Samples pass through a four-item queue into the compute engine, which
//   writes each into the work RAM at its bit-reversed address. After the
//   last sample, 192 butterflies run one after another, each reading its two
//   points, forming the twiddle products, summing and writing both results
//   back. Each bin is then read, registered and handed off, and is held
//   while the receiver stalls. The engine takes no new sample until the
//   last bin of a frame is handed off, but the queue keeps accepting the
//   next frame's first four samples while a transform runs.
//   While rsp_stall is high the bin held on rsp_* stays unchanged.
//   Reset empties the queue, clears the sample count and idles the engine.
// ----------------------------------------------------------------------------
module fft_64_point_radix2 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fft64_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [fft64_pkg::SAMPLE_W-1:0] req_sample_im,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fft64_pkg::DATA_W-1:0]   rsp_bin_re,
   output logic signed [fft64_pkg::DATA_W-1:0]   rsp_bin_im,
   output logic                                 rsp_bin_last
);

   logic                   q_valid;
   logic                   q_pop;
   fft64_pkg::q_entry_type q_entry;

   fft64_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   fft64_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bin_re   (rsp_bin_re),
      .rsp_bin_im   (rsp_bin_im),
      .rsp_bin_last (rsp_bin_last)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives 64-sample frames into the FFT, predicts every bin with a fixed-point
// transform of its own and checks the bins as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SW          = fft64_pkg::SAMPLE_W;
   localparam int DW          = fft64_pkg::DATA_W;
   localparam int NPTS        = fft64_pkg::POINTS;
   localparam int NFRAMES     = 4;                     // 256 samples
   localparam int TAIL        = 14;                    // partial frame, no bins
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
   } sample_type;

   typedef struct packed {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 last;
   } bin_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_sample_re = '0;
   logic signed [SW-1:0] req_sample_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_bin_re;
   logic signed [DW-1:0] rsp_bin_im;
   logic rsp_bin_last;

   sample_type pending_samples[$];
   bin_type    expected_bins[$];
   logic signed [DW-1:0] frame_re[NPTS];
   logic signed [DW-1:0] frame_im[NPTS];
   int frame_fill = 0;
   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   logic stimulus_done = 1'b0;
   logic took_q = 1'b0;

   fft_64_point_radix2 u_top (.*);

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic signed [DW-1:0] clip(input longint v);
      longint hi;
      hi = (64'sd1 <<< (DW-1)) - 1;
      if (v > hi) return DW'(hi);
      if (v < -hi-1) return DW'(-hi-1);
      return DW'(v);
   endfunction

   // ties toward +inf, floor shift
   function automatic longint round_q15(input longint p);
      return (p + 64'sd16384) >>> 15;
   endfunction

   function automatic longint cos_q15(input int k);
      if (k == 0) return 32767;
      return longint'($rtoi($floor(32768.0 * $cos(2.0 * 3.14159265358979 * k / 64.0)
                                   + 0.5)));
   endfunction

   // load one sample at its bit-reversed slot; run the transform on the 64th
   task automatic predict_sample(input sample_type s);
      int a, r, half, start, j, kk, c, k;
      longint wr, wi, tr, ti, cr, ci;
      a = frame_fill;
      r = 0;
      for (int b = 0; b < 6; b++) r = (r << 1) | ((a >> b) & 1);
      frame_re[r] = DW'(s.re);
      frame_im[r] = DW'(s.im);
      frame_fill++;
      if (frame_fill < NPTS) return;
      frame_fill = 0;
      for (half = 1; half < NPTS; half *= 2)
         for (start = 0; start < NPTS; start += 2 * half)
            for (j = 0; j < half; j++) begin
               c = start + j;
               k = c + half;
               kk = (j * (NPTS / (2 * half))) % 32;
               if (kk <= 16) begin
                  wr = cos_q15(kk);
                  wi = -cos_q15(16 - kk);
               end else begin
                  wr = -cos_q15(32 - kk);
                  wi = -cos_q15(kk - 16);
               end
               tr = round_q15(longint'(frame_re[k]) * wr - longint'(frame_im[k]) * wi);
               ti = round_q15(longint'(frame_re[k]) * wi + longint'(frame_im[k]) * wr);
               cr = frame_re[c];
               ci = frame_im[c];
               frame_re[k] = clip(cr - tr);
               frame_im[k] = clip(ci - ti);
               frame_re[c] = clip(cr + tr);
               frame_im[c] = clip(ci + ti);
            end
      for (int n = 0; n < NPTS; n++)
         expected_bins.push_back('{frame_re[n], frame_im[n], n == NPTS - 1});
   endtask

   initial begin
      sample_type s;
      int mode;
      // frame 0: directed extremes, an eight-sample pattern of full-scale and mixed values repeated over the frame
      for (int n = 0; n < NPTS; n++) begin
         case (n % 8)
            0: s = '{16'sh7fff, 16'sh7fff};
            1: s = '{16'sh8000, 16'sh8000};
            2: s = '{16'sh7fff, 16'sh8000};
            3: s = '{16'sh0000, 16'sh0000};
            4: s = '{16'sh8000, 16'sh7fff};
            5: s = '{16'sh5555, 16'shaaaa};
            6: s = '{16'shaaaa, 16'sh5555};
            default: s = '{16'shffff, 16'sh0001};
         endcase
         pending_samples.push_back(s);
      end
      // frame 1: all maximum negative, a full-scale constant whose energy lands in the DC bin
      for (int n = 0; n < NPTS; n++) pending_samples.push_back('{16'sh8000, 16'sh8000});
      for (int f = 2; f < NFRAMES; f++) begin
         mode = $urandom_range(0, 2);
         for (int n = 0; n < NPTS; n++) begin
            s.re = SW'($urandom);
            s.im = SW'($urandom);
            if (mode == 1) begin
               s.re = $signed(s.re) >>> 8;
               s.im = $signed(s.im) >>> 8;
            end
            pending_samples.push_back(s);
         end
      end
      // trailing partial frame: loads but must produce no bins
      for (int n = 0; n < TAIL; n++) begin
         s.re = SW'($urandom);
         s.im = SW'($urandom);
         pending_samples.push_back(s);
      end
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   // sender: bursts with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || took_q) begin
            if (pending_samples.size() != 0 && gap_left == 0) begin
               req_valid <= 1'b1;
               req_sample_re <= pending_samples[0].re;
               req_sample_im <= pending_samples[0].im;
               void'(pending_samples.pop_front());
               if (burst_left == 0) burst_left = $urandom_range(1, 40);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
               if (pending_samples.size() == 0) stimulus_done <= 1'b1;
            end
         end
         // receiver stall pattern: quiet stretches and busy stretches
         rsp_stall <= (cycle_count % 700 < 300) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      bin_type want;
      cycle_count++;
      took_q <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_sample('{req_sample_re, req_sample_im});
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) report_mismatch("bin with none expected");
            else begin
               want = expected_bins.pop_front();
               if (rsp_bin_re !== want.re)
                  report_mismatch($sformatf("bin_re %0d want %0d", rsp_bin_re, want.re));
               if (rsp_bin_im !== want.im)
                  report_mismatch($sformatf("bin_im %0d want %0d", rsp_bin_im, want.im));
               if (rsp_bin_last !== want.last)
                  report_mismatch($sformatf("bin_last %0b want %0b", rsp_bin_last, want.last));
            end
         end
      end
   end

   initial begin
      wait (stimulus_done && !req_valid && expected_bins.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end
endmodule
